// ===== rtl/twsrm_pkg.sv =====
// Package for the two-wire sensor read master: item structs, phase codes,
// register indexes and the start pattern table. No dependencies.
`default_nettype none

package twsrm_pkg;

  typedef struct packed {
    logic start_req;
    logic cmd;
    logic data_pin_in;
  } in_item_t;

  typedef struct packed {
    logic        clock_pin;
    logic        data_pin_out;
    logic        data_drive;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] raw_value;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_START, PH_CMD_SET, PH_CMD_HI, PH_CMD_LO, PH_ACK_HI, PH_ACK_LO,
    PH_WAIT, PH_RD_HI, PH_RD_HOLD, PH_RD_LO,
    PH_MACK0, PH_MACK1, PH_MACK2, PH_MACK3, PH_CRC0, PH_CRC1, PH_CRC2
  } phase_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_TICKS  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_HOLD  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAIT_LIMIT   = 2'd2;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd1;
  localparam logic [15:0] SAMPLE_HOLD_RESET = 16'd1000;
  localparam logic [23:0] WAIT_LIMIT_RESET  = 24'd1000000;

  localparam logic [7:0] CMD_TEMPERATURE = 8'h03;
  localparam logic [7:0] CMD_HUMIDITY    = 8'h05;

  // Start pattern step -> {data, clock}; steps past the end give data high, clock low.
  function automatic logic [1:0] start_levels(input logic [3:0] step);
    logic [1:0] lv;
    unique case (step)
      4'd0:    lv = 2'b10;
      4'd1:    lv = 2'b11;
      4'd2:    lv = 2'b01;
      4'd3:    lv = 2'b00;
      4'd4:    lv = 2'b01;
      4'd5:    lv = 2'b11;
      default: lv = 2'b10;
    endcase
    return lv;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/two_wire_sensor_read_master.sv =====
// Top level of the two-wire sensor read master: pin sequencer and result register.
// Depends on twsrm_pkg for the item structs, phase codes and start pattern.
`default_nettype none

// Each input item is one tick of the pin sequencer and yields exactly one result
// item. The whole tick is evaluated combinationally from the sequencer state
// and the incoming item, and the result lands in an output register, so one item
// is taken per clock (in_ready stays high while the output register is empty or
// being drained). A start request is honored only while idle; the transaction then
// runs the start pattern, the command byte, the sensor ack, the measurement wait,
// two read bytes with a master ack between them and a no-ack that skips the CRC.
// Configuration writes are taken in any cycle (cfg_ready is always high).
module two_wire_sensor_read_master #(
  parameter int WAIT_COUNTER_BITS = 24,
  parameter int TICK_COUNTER_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire twsrm_pkg::in_item_t                  in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output twsrm_pkg::out_item_t                      out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [twsrm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [twsrm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import twsrm_pkg::*;

  localparam int TB  = TICK_COUNTER_BITS;
  localparam int WB  = WAIT_COUNTER_BITS;
  localparam int TLW = (TB + 1 > 17) ? TB + 1 : 17;
  localparam int WLW = (WB + 1 > 25) ? WB + 1 : 25;
  localparam logic [TLW-1:0] TICK_CAP = TLW'(1) << TB;
  localparam logic [WLW-1:0] WAIT_MAX = (WLW'(1) << WB) - WLW'(1);

  // configuration
  logic [15:0] phase_ticks;
  logic [15:0] sample_hold_ticks;
  logic [23:0] wait_limit;

  // sequencer state
  phase_t          phase, phase_next;
  logic [3:0]      bit_index, bit_index_next;
  logic [TB-1:0]   tick_count, tick_count_next;
  logic [WB-1:0]   wait_count, wait_count_next;
  logic [7:0]      command_shift, command_shift_next;
  logic [15:0]     result_shift, result_shift_next;
  logic            lv_clk, lv_clk_next;
  logic            lv_dat, lv_dat_next;
  logic            lv_drv, lv_drv_next;
  out_item_t       result;

  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks       <= PHASE_TICKS_RESET;
      sample_hold_ticks <= SAMPLE_HOLD_RESET;
      wait_limit        <= WAIT_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_TICKS: phase_ticks       <= cfg_data[15:0];
        REG_SAMPLE_HOLD: sample_hold_ticks <= cfg_data[15:0];
        REG_WAIT_LIMIT:  wait_limit        <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // One tick of the sequencer.
  always_comb begin
    logic [15:0]    len;
    logic [TLW-1:0] lim;
    logic [TLW-1:0] tick_inc;
    logic [WLW-1:0] wlim;
    logic [WLW-1:0] wait_inc;
    logic           cbit;
    logic           phase_end;
    logic [1:0]     st;

    phase_next         = phase;
    bit_index_next     = bit_index;
    tick_count_next    = tick_count;
    wait_count_next    = wait_count;
    command_shift_next = command_shift;
    result_shift_next  = result_shift;
    lv_clk_next        = lv_clk;
    lv_dat_next        = lv_dat;
    lv_drv_next        = lv_drv;
    result             = '0;
    len                = '0;
    lim                = '0;
    tick_inc           = '0;
    wlim               = '0;
    wait_inc           = '0;
    phase_end          = 1'b0;

    if (phase_next == PH_IDLE && in_data.start_req) begin
      phase_next         = PH_START;
      bit_index_next     = '0;
      tick_count_next    = '0;
      wait_count_next    = '0;
      command_shift_next = in_data.cmd ? CMD_HUMIDITY : CMD_TEMPERATURE;
      result_shift_next  = '0;
    end

    cbit = command_shift_next[3'd7 - bit_index_next[2:0]];
    st   = start_levels(bit_index_next);

    if (phase_next != PH_IDLE) begin
      result.busy_res = 1'b1;

      unique case (phase_next)
        PH_START: begin
          lv_drv_next = 1'b1; lv_dat_next = st[1]; lv_clk_next = st[0];
        end
        PH_CMD_SET, PH_CMD_LO: begin
          lv_drv_next = 1'b1; lv_dat_next = cbit; lv_clk_next = 1'b0;
        end
        PH_CMD_HI: begin
          lv_drv_next = 1'b1; lv_dat_next = cbit; lv_clk_next = 1'b1;
        end
        PH_ACK_HI: begin
          lv_drv_next = 1'b1; lv_clk_next = 1'b1;
        end
        PH_ACK_LO: begin
          lv_drv_next = 1'b1; lv_clk_next = 1'b0;
        end
        PH_WAIT, PH_RD_LO: begin
          lv_drv_next = 1'b0; lv_clk_next = 1'b0;
        end
        PH_RD_HI, PH_RD_HOLD: begin
          lv_drv_next = 1'b0; lv_clk_next = 1'b1;
        end
        PH_MACK0, PH_CRC0, PH_CRC2: begin
          lv_drv_next = 1'b1; lv_dat_next = 1'b1; lv_clk_next = 1'b0;
        end
        PH_MACK1, PH_MACK3: begin
          lv_drv_next = 1'b1; lv_dat_next = 1'b0; lv_clk_next = 1'b0;
        end
        PH_MACK2: begin
          lv_drv_next = 1'b1; lv_dat_next = 1'b0; lv_clk_next = 1'b1;
        end
        PH_CRC1: begin
          lv_drv_next = 1'b1; lv_dat_next = 1'b1; lv_clk_next = 1'b1;
        end
        default: ;
      endcase

      // phase timer: zero length counts as one, length clamps to the counter range
      len      = (phase_next == PH_RD_HOLD) ? sample_hold_ticks : phase_ticks;
      lim      = (len == 16'd0) ? TLW'(1) : TLW'(len);
      if (lim > TICK_CAP) lim = TICK_CAP;
      tick_inc = TLW'(tick_count_next) + TLW'(1);

      wlim     = (WLW'(wait_limit) < WAIT_MAX) ? WLW'(wait_limit) : WAIT_MAX;
      wait_inc = WLW'(wait_count_next) + WLW'(1);

      phase_end = 1'b0;
      if (phase_next == PH_WAIT) begin
        if (!in_data.data_pin_in) begin
          phase_next      = PH_RD_HI;
          bit_index_next  = '0;
          tick_count_next = '0;
        end else if (wait_inc > wlim) begin
          result.done_res  = 1'b1;
          result.timed_out = 1'b1;
          phase_next       = PH_IDLE;
          wait_count_next  = '0;
        end else begin
          wait_count_next = wait_inc[WB-1:0];
        end
      end else if (tick_inc >= lim) begin
        tick_count_next = '0;
        phase_end       = 1'b1;
      end else begin
        tick_count_next = tick_inc[TB-1:0];
      end

      if (phase_end) begin
        unique case (phase_next)
          PH_START: begin
            if (bit_index_next < 4'd6) bit_index_next = bit_index_next + 4'd1;
            else begin
              bit_index_next = '0;
              phase_next     = PH_CMD_SET;
            end
          end
          PH_CMD_SET: phase_next = PH_CMD_HI;
          PH_CMD_HI:  phase_next = PH_CMD_LO;
          PH_CMD_LO: begin
            if (bit_index_next < 4'd7) begin
              bit_index_next = bit_index_next + 4'd1;
              phase_next     = PH_CMD_SET;
            end else begin
              bit_index_next = '0;
              phase_next     = PH_ACK_HI;
            end
          end
          PH_ACK_HI: phase_next = PH_ACK_LO;
          PH_ACK_LO: begin
            phase_next      = PH_WAIT;
            wait_count_next = '0;
          end
          PH_RD_HI: begin
            if (sample_hold_ticks == 16'd0) begin
              result_shift_next = {result_shift_next[14:0], in_data.data_pin_in};
              phase_next        = PH_RD_LO;
            end else begin
              phase_next = PH_RD_HOLD;
            end
          end
          PH_RD_HOLD: begin
            result_shift_next = {result_shift_next[14:0], in_data.data_pin_in};
            phase_next        = PH_RD_LO;
          end
          PH_RD_LO: begin
            priority if (bit_index_next == 4'd7) begin
              bit_index_next = 4'd8;
              phase_next     = PH_MACK0;
            end else if (bit_index_next == 4'd15) begin
              bit_index_next = '0;
              phase_next     = PH_CRC0;
            end else begin
              bit_index_next = bit_index_next + 4'd1;
              phase_next     = PH_RD_HI;
            end
          end
          PH_MACK0: phase_next = PH_MACK1;
          PH_MACK1: phase_next = PH_MACK2;
          PH_MACK2: phase_next = PH_MACK3;
          PH_MACK3: phase_next = PH_RD_HI;
          PH_CRC0:  phase_next = PH_CRC1;
          PH_CRC1:  phase_next = PH_CRC2;
          PH_CRC2: begin
            result.done_res  = 1'b1;
            result.raw_value = result_shift_next;
            phase_next       = PH_IDLE;
          end
          default: ;
        endcase
      end

      if (result.done_res) result.busy_res = 1'b0;
    end

    result.clock_pin    = lv_clk_next;
    result.data_pin_out = lv_dat_next;
    result.data_drive   = lv_drv_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= '0;
      tick_count    <= '0;
      wait_count    <= '0;
      command_shift <= '0;
      result_shift  <= '0;
      lv_clk        <= 1'b0;
      lv_dat        <= 1'b1;
      lv_drv        <= 1'b0;
    end else if (in_fire) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      tick_count    <= tick_count_next;
      wait_count    <= wait_count_next;
      command_shift <= command_shift_next;
      result_shift  <= result_shift_next;
      lv_clk        <= lv_clk_next;
      lv_dat        <= lv_dat_next;
      lv_drv        <= lv_drv_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
